// File: rtl/core/irpw_pkg.sv
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants of the IR pulse-width frame decoder: register
// indexes, reset nominals, frame bit positions and the pulse class bundle.
// ----------------------------------------------------------------------------
package irpw_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_NOMINAL = 2'd0,
    CFG_ONE_NOMINAL   = 2'd1,
    CFG_ZERO_NOMINAL  = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_INDEX_BITS = 2;

  // reset nominals, truncated to the timer width at the top level
  localparam logic [31:0] START_NOMINAL_RESET = 32'd4000;
  localparam logic [31:0] ONE_NOMINAL_RESET   = 32'd2000;
  localparam logic [31:0] ZERO_NOMINAL_RESET  = 32'd1000;

  // frame layout, bit positions in receive order
  localparam logic [4:0] LAST_ID_BIT    = 5'd2;
  localparam logic [4:0] FIRST_DATA_BIT = 5'd3;
  localparam logic [4:0] LAST_DATA_BIT  = 5'd10;
  localparam logic [4:0] FIRST_SLOT_BIT = 5'd11;
  localparam logic [4:0] LAST_SLOT_BIT  = 5'd15;
  localparam logic [4:0] PARITY_BIT     = 5'd16;

  localparam int unsigned ID_BITS      = 3;
  localparam int unsigned PAYLOAD_BITS = 8;
  localparam int unsigned SLOT_BITS    = 5;

  // window matches of one registered pulse
  typedef struct packed {
    logic is_start;
    logic is_one;
    logic is_zero;
  } pulse_class_t;

endpackage

// File: rtl/core/irpw_if.sv
// ----------------------------------------------------------------------------
// irpw_if
// Valid/ready channels of the decoder: measured pulse widths in, decoded
// frames out.
// ----------------------------------------------------------------------------
interface irpw_pulse_if #(
  parameter int unsigned WIDTH_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink (input valid, input pulse_width, output ready);
endinterface

interface irpw_frame_if;
  logic       valid;
  logic       ready;
  logic [2:0] sender_id;
  logic [7:0] payload;
  logic [4:0] slot;
  logic       parity_ok;

  modport source (output valid, output sender_id, output payload, output slot,
                  output parity_ok, input ready);
  modport sink (input valid, input sender_id, input payload, input slot,
                input parity_ok, output ready);
endinterface

// File: rtl/core/irpw_window.sv
// ----------------------------------------------------------------------------
// irpw_window
// Tolerance window compare: a width matches a nominal when it lies strictly
// between 3*(nominal>>2) and 5*(nominal>>2).
// ----------------------------------------------------------------------------
module irpw_window #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic [WIDTH_BITS-1:0] width,
  input  logic [WIDTH_BITS-1:0] nominal,
  output logic                  match
);

  logic [WIDTH_BITS:0] quarter;
  logic [WIDTH_BITS:0] low_bound;
  logic [WIDTH_BITS:0] high_bound;
  logic [WIDTH_BITS:0] width_ext;

  // one extra bit keeps 5*quarter from wrapping
  assign quarter    = {3'b000, nominal[WIDTH_BITS-1:2]};
  assign low_bound  = quarter + (quarter << 1);
  assign high_bound = quarter + (quarter << 2);
  assign width_ext  = {1'b0, width};

  assign match = (width_ext > low_bound) && (width_ext < high_bound);

endmodule

// File: rtl/core/irpw_frame.sv
// ----------------------------------------------------------------------------
// irpw_frame
// Frame tracker: opens a frame on a start pulse, shifts in 17 bits LSB
// first, aborts on any other width, and loads the result register.
// ----------------------------------------------------------------------------
module irpw_frame
  import irpw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pulse_class_t        pclass,
  irpw_frame_if.source        frame
);

  logic                    in_frame;
  logic                    in_frame_next;
  logic [4:0]              bit_index;
  logic [4:0]              bit_index_next;
  logic [ID_BITS-1:0]      id_shift;
  logic [ID_BITS-1:0]      id_shift_next;
  logic [PAYLOAD_BITS-1:0] data_shift;
  logic [PAYLOAD_BITS-1:0] data_shift_next;
  logic [SLOT_BITS-1:0]    slot_shift;
  logic [SLOT_BITS-1:0]    slot_shift_next;
  logic                    parity_received;
  logic                    parity_received_next;
  logic                    emit;
  logic                    bit_value;
  logic [4:0]              data_offset;
  logic [4:0]              slot_offset;

  assign bit_value   = pclass.is_one;
  assign data_offset = bit_index - FIRST_DATA_BIT;
  assign slot_offset = bit_index - FIRST_SLOT_BIT;

  // classify-and-shift step for one beat
  always_comb begin
    in_frame_next        = in_frame;
    bit_index_next       = bit_index;
    id_shift_next        = id_shift;
    data_shift_next      = data_shift;
    slot_shift_next      = slot_shift;
    parity_received_next = parity_received;
    emit                 = 1'b0;
    if (step) begin
      if (!in_frame) begin
        if (pclass.is_start) begin
          in_frame_next   = 1'b1;
          bit_index_next  = '0;
          data_shift_next = '0;
          slot_shift_next = '0;
        end
      end else if (pclass.is_one || pclass.is_zero) begin
        // place the bit in the field its position belongs to
        if (bit_index <= LAST_ID_BIT) begin
          id_shift_next[bit_index[1:0]] = bit_value;
        end else if (bit_index <= LAST_DATA_BIT) begin
          data_shift_next[data_offset[2:0]] = bit_value;
        end else if (bit_index <= LAST_SLOT_BIT) begin
          slot_shift_next[slot_offset[2:0]] = bit_value;
        end else if (bit_index == PARITY_BIT) begin
          parity_received_next = bit_value;
        end
        bit_index_next = bit_index + 5'd1;
        if (bit_index == PARITY_BIT) begin
          in_frame_next = 1'b0;
          emit          = 1'b1;
        end
      end else begin
        // unexpected width aborts, shift contents stay
        in_frame_next = 1'b0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      bit_index       <= '0;
      id_shift        <= '0;
      data_shift      <= '0;
      slot_shift      <= '0;
      parity_received <= 1'b0;
    end else begin
      in_frame        <= in_frame_next;
      bit_index       <= bit_index_next;
      id_shift        <= id_shift_next;
      data_shift      <= data_shift_next;
      slot_shift      <= slot_shift_next;
      parity_received <= parity_received_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (emit) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame.sender_id <= id_shift_next;
      frame.payload   <= data_shift_next;
      frame.slot      <= slot_shift_next;
      frame.parity_ok <= ^{id_shift_next, data_shift_next, slot_shift_next,
                           parity_received_next};
    end
  end

endmodule

// File: rtl/core/ir_pulse_width_frame_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder
// Decodes 17-bit IR frames from a stream of measured low-pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   pulse  - sink channel, one measured pulse width per beat
//   frame  - source channel, one beat per completed frame: sender id,
//            payload, slot and an odd-parity check
//   cfg_*  - write port for the start, one and zero nominal widths;
//            write only while no pulse is in flight
// Path: a frame's last accepted pulse passes the input register, then
// the result register. Throughput: one pulse per cycle while no frame
// beat waits on frame.ready; the window compares and the shift step
// sit between the input register and the state/result registers.
// Reset: nominals return to 4000, 2000 and 1000 (cut to WIDTH_BITS), the
// decoder goes idle and both channels are empty.
// Stall: while a frame beat waits on frame.ready, one more pulse is held
// in the input register; pulse.ready then drops until the frame is taken.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder
  import irpw_pkg::*;
#(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  irpw_pulse_if.sink                pulse,
  irpw_frame_if.source              frame,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WIDTH_BITS-1:0]     cfg_wr_data
);

  logic [WIDTH_BITS-1:0] start_nominal;
  logic [WIDTH_BITS-1:0] one_nominal;
  logic [WIDTH_BITS-1:0] zero_nominal;
  logic                  held_valid;
  logic [WIDTH_BITS-1:0] held_width;
  logic                  step;
  pulse_class_t          pclass;

  // nominal registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_nominal <= START_NOMINAL_RESET[WIDTH_BITS-1:0];
      one_nominal   <= ONE_NOMINAL_RESET[WIDTH_BITS-1:0];
      zero_nominal  <= ZERO_NOMINAL_RESET[WIDTH_BITS-1:0];
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_START_NOMINAL) begin
        start_nominal <= cfg_wr_data;
      end
      if (cfg_index == CFG_ONE_NOMINAL) begin
        one_nominal <= cfg_wr_data;
      end
      if (cfg_index == CFG_ZERO_NOMINAL) begin
        zero_nominal <= cfg_wr_data;
      end
    end
  end

  // input register, drains whenever the result register can take a beat
  assign step        = held_valid && (!frame.valid || frame.ready);
  assign pulse.ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pulse.ready) begin
      held_valid <= pulse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse.valid && pulse.ready) begin
      held_width <= pulse.pulse_width;
    end
  end

  // window compares
  irpw_window #(.WIDTH_BITS(WIDTH_BITS)) u_start_window (
    .width   (held_width),
    .nominal (start_nominal),
    .match   (pclass.is_start)
  );

  irpw_window #(.WIDTH_BITS(WIDTH_BITS)) u_one_window (
    .width   (held_width),
    .nominal (one_nominal),
    .match   (pclass.is_one)
  );

  irpw_window #(.WIDTH_BITS(WIDTH_BITS)) u_zero_window (
    .width   (held_width),
    .nominal (zero_nominal),
    .match   (pclass.is_zero)
  );

  // frame tracker and result register
  irpw_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .pclass (pclass),
    .frame  (frame)
  );

endmodule

// File: rtl/core/irpw_checker.sv
// ----------------------------------------------------------------------------
// irpw_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module irpw_checker (
  input logic clk,
  input logic rst,
  input logic pulse_valid,
  input logic pulse_ready,
  input logic frame_valid,
  input logic frame_ready,
  input logic [2:0] frame_sender_id,
  input logic [7:0] frame_payload,
  input logic [4:0] frame_slot,
  input logic frame_parity_ok
);

  // a pending frame beat stays until taken
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid)
    else $error("frame beat dropped while stalled");

  // a pending frame beat keeps its fields
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=>
      $stable(frame_sender_id) && $stable(frame_payload) &&
      $stable(frame_slot) && $stable(frame_parity_ok))
    else $error("frame fields changed while stalled");

  // input back-pressure only comes from a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !pulse_ready |-> frame_valid && !frame_ready)
    else $error("pulse channel stalled without a stalled frame");

  // a new result follows an earlier accepted pulse
  assert property (@(posedge clk) disable iff (rst)
    $rose(frame_valid) |-> $past(pulse_valid && pulse_ready, 2))
    else $error("frame beat without a recent pulse");

endmodule

bind ir_pulse_width_frame_decoder irpw_checker u_irpw_checker (
  .clk             (clk),
  .rst             (rst),
  .pulse_valid     (pulse.valid),
  .pulse_ready     (pulse.ready),
  .frame_valid     (frame.valid),
  .frame_ready     (frame.ready),
  .frame_sender_id (frame.sender_id),
  .frame_payload   (frame.payload),
  .frame_slot      (frame.slot),
  .frame_parity_ok (frame.parity_ok)
);
